@@ src/fmpd_pkg.sv @@
// Shared types, constants and the phase quantizer table for the FM phase-delta discriminator.
// Has no dependencies; every other file in src imports it.
package fmpd_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned PhaseW  = 5;
  localparam int unsigned CodeW   = 6;
  localparam int unsigned PedW    = 6;
  localparam int unsigned GainW   = 3;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 8;

  localparam logic [CfgIdxW-1:0] CFG_IDX_PEDESTAL = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_GAIN     = 8'd1;

  localparam logic [PedW-1:0]   PEDESTAL_RESET   = 6'd20;
  localparam logic [GainW-1:0]  GAIN_RESET       = 3'd2;
  // phase of an all-zero byte
  localparam logic [PhaseW-1:0] LAST_PHASE_RESET = 5'd4;

  localparam logic [CodeW-1:0]  CODE_MAX = 6'd63;

  typedef struct packed {
    logic [PedW-1:0]  pedestal;
    logic [GainW-1:0] gain_setting;
  } cfg_t;

  typedef logic [255:0][PhaseW-1:0] phase_rom_t;

  localparam longint unsigned TanScale = 64'd1000000000000;
  // tan((2m+1)*pi/32) scaled by 10^12, m = 0..7 (index 0 is the last entry)
  localparam logic [7:0][63:0] TanBound = {
    64'd10153170387609, 64'd3296558208938, 64'd1870868411789, 64'd1218503525588,
    64'd820678790829,   64'd534511135951,  64'd303346683607,  64'd98491403357
  };

  // Twice the bucket centre of a signed 4-bit bucket code.
  function automatic int bucket2(int nib);
    int s;
    s = nib;
    if (s >= 8) s = s - 16;
    return s * 128 + 63;
  endfunction

  // Evaluated at elaboration only, to build the quantizer table.
  function automatic phase_rom_t build_phase_rom();
    phase_rom_t       rom;
    int               q;
    int               i;
    int               p0;
    int               ph;
    longint unsigned  ay;
    longint unsigned  ax;
    for (int b = 0; b < 256; b++) begin
      q  = bucket2(b % 16);
      i  = bucket2(b / 16);
      ay = longint'((q < 0) ? -q : q);
      ax = longint'((i < 0) ? -i : i);
      p0 = 0;
      for (int m = 0; m < 8; m++) begin
        if (ay * TanScale > ax * TanBound[m]) p0 = p0 + 1;
      end
      if (i > 0 && q > 0)      ph = p0;
      else if (i < 0 && q > 0) ph = 16 - p0;
      else if (i < 0)          ph = 16 + p0;
      else                     ph = 32 - p0;
      rom[b] = PhaseW'(ph % 32);
    end
    return rom;
  endfunction

  localparam phase_rom_t PHASE_ROM = build_phase_rom();

endpackage

@@ src/fmpd_phase_lane.sv @@
// One quantizer lane: looks up the 5-bit phase of a packed I/Q byte and registers it.
// Depends on fmpd_pkg for the phase table.
module fmpd_phase_lane import fmpd_pkg::*; (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [PhaseW-1:0]  phase_o
);

  logic [PhaseW-1:0] phase_q;
  logic [PhaseW-1:0] phase_d;

  assign phase_d = PHASE_ROM[sample_i];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

@@ src/fmpd_merge.sv @@
// Merge stage: combines the two lane phases with the stored last phase, scales, clamps
// and holds the result in the output register. Depends on fmpd_pkg.
module fmpd_merge import fmpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [PhaseW-1:0] phase_a_i,
  input  logic [PhaseW-1:0] phase_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CodeW-1:0]  freq_code_o
);

  logic [PhaseW-1:0]  last_phase_q;
  logic               out_valid_q;
  logic [CodeW-1:0]   code_q;
  logic [CodeW-1:0]   code_d;
  logic               advance;

  logic [PhaseW-1:0]  delta1;
  logic [PhaseW-1:0]  delta2;
  logic signed [6:0]  sum;
  logic signed [4:0]  gain_p1;
  logic signed [11:0] prod;
  logic signed [12:0] scaled;
  logic signed [13:0] code_wide;

  assign ready_o = !out_valid_q || out_ready_i;
  assign advance = valid_i && ready_o;

  always_comb begin
    delta1    = phase_a_i - last_phase_q;
    delta2    = phase_b_i - phase_a_i;
    sum       = $signed({{2{delta1[PhaseW-1]}}, delta1})
              + $signed({{2{delta2[PhaseW-1]}}, delta2});
    gain_p1   = $signed({2'b00, cfg_i.gain_setting}) + 5'sd1;
    // 8*(g+1)/4 is exact, so the rounding never comes into play
    prod      = sum * gain_p1;
    scaled    = {prod, 1'b0};
    code_wide = $signed({8'b0, cfg_i.pedestal}) + $signed({scaled[12], scaled});
    priority if (code_wide < 14'sd0) begin
      code_d = '0;
    end else if (code_wide > $signed({8'b0, CODE_MAX})) begin
      code_d = CODE_MAX;
    end else begin
      code_d = code_wide[CodeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= LAST_PHASE_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        last_phase_q <= phase_b_i;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign freq_code_o = code_q;

  a_last_phase_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> last_phase_q == $past(phase_b_i))
    else $error("last phase did not take the second sample phase");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("accepted request did not reach the output register");

  a_stall_holds_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(code_q))
    else $error("stalled result changed or dropped");

endmodule

@@ src/fm_phase_delta_discriminator.sv @@
// FM phase-delta discriminator, top level: two quantizer lanes, a merge stage and config.
// An accepted request is held in the stage-1 lane registers, then in the merge output register.
// Throughput: one request per cycle while freq_code_o is not stalled; the last-phase recurrence
// closes inside the merge stage, and the phase table is a constant lookup in each lane.
// Reset (rst_ni low, asynchronous): pipeline empties, pedestal 20, gain 2, last phase 4.
// Depends on fmpd_pkg, fmpd_phase_lane and fmpd_merge.
module fm_phase_delta_discriminator import fmpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample pair requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_first_i,
  input  logic [SampleW-1:0] sample_second_i,
  // frequency codes
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CodeW-1:0]   freq_code_o,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              s1_valid_q;
  logic              merge_ready;
  logic              lane_load;
  logic [PhaseW-1:0] phase_a;
  logic [PhaseW-1:0] phase_b;

  // Register writes are always taken; unknown indexes drop silently.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pedestal     <= PEDESTAL_RESET;
      cfg_q.gain_setting <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_PEDESTAL: cfg_q.pedestal     <= cfg_data_i[PedW-1:0];
        CFG_IDX_GAIN:     cfg_q.gain_setting <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1 holds the two looked-up phases; it frees up whenever the merge stage moves.
  assign in_ready_o = !s1_valid_q || merge_ready;
  assign lane_load  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Lane 0 quantizes the first sample, lane 1 the second.
  fmpd_phase_lane u_lane_first (
    .clk_i    (clk_i),
    .load_i   (lane_load),
    .sample_i (sample_first_i),
    .phase_o  (phase_a)
  );

  fmpd_phase_lane u_lane_second (
    .clk_i    (clk_i),
    .load_i   (lane_load),
    .sample_i (sample_second_i),
    .phase_o  (phase_b)
  );

  // Merge: both deltas, scale, pedestal, clamp and the output register.
  fmpd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (s1_valid_q),
    .ready_o     (merge_ready),
    .phase_a_i   (phase_a),
    .phase_b_i   (phase_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .freq_code_o (freq_code_o)
  );

  a_stage1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !merge_ready |=> s1_valid_q && $stable(phase_a) && $stable(phase_b))
    else $error("stage 1 lost or changed a stalled request");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with an empty stage 1");

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_load |=> s1_valid_q)
    else $error("accepted request did not reach stage 1");

endmodule

@@ test/fm_phase_delta_discriminator_checker.sv @@
// Checker for the FM phase-delta discriminator: watches the sample, code and register channels,
// predicts each frequency code from its own phase quantizer and compares in order.
// Depends on fmpd_pkg for widths, register indexes and reset values.
module fm_phase_delta_discriminator_checker import fmpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [SampleW-1:0] sample_first_i,
  input  logic [SampleW-1:0] sample_second_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [CodeW-1:0]   freq_code_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output int                 mismatch_count_o,
  output int                 codes_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TanOne = 64'd1000000000000;

  logic [CodeW-1:0]   codes_owed_q[$];
  logic [PedW-1:0]    pedestal_copy;
  logic [GainW-1:0]   gain_copy;
  logic [PhaseW-1:0]  prev_phase;
  logic [PhaseW-1:0]  phase_a;
  logic [PhaseW-1:0]  phase_b;
  logic [CodeW-1:0]   owed_code;
  int                 errors;

  // tan((2m+1)*pi/32) scaled by 10^12: the edges between phase steps in one octant pair
  function automatic longint unsigned step_edge(int m);
    case (m)
      0: return 64'd98491403357;
      1: return 64'd303346683607;
      2: return 64'd534511135951;
      3: return 64'd820678790829;
      4: return 64'd1218503525588;
      5: return 64'd1870868411789;
      6: return 64'd3296558208938;
      default: return 64'd10153170387609;
    endcase
  endfunction

  function automatic logic [PhaseW-1:0] quantize_phase(logic [SampleW-1:0] iq);
    int               q_c;
    int               i_c;
    int               steps;
    int               m;
    longint unsigned  q_mag;
    longint unsigned  i_mag;
    q_c   = int'($signed(iq[3:0])) * 128 + 63;
    i_c   = int'($signed(iq[7:4])) * 128 + 63;
    q_mag = (q_c < 0) ? longint'(-q_c) : longint'(q_c);
    i_mag = (i_c < 0) ? longint'(-i_c) : longint'(i_c);
    steps = 0;
    for (m = 0; m < 8; m++) begin
      if (q_mag * TanOne > i_mag * step_edge(m)) steps++;
    end
    if (i_c > 0 && q_c > 0) return PhaseW'(steps);
    else if (i_c < 0 && q_c > 0) return PhaseW'(16 - steps);
    else if (i_c < 0) return PhaseW'(16 + steps);
    else return PhaseW'(32 - steps);
  endfunction

  function automatic logic [CodeW-1:0] freq_from_phases(logic [PhaseW-1:0] prev,
                                                        logic [PhaseW-1:0] a,
                                                        logic [PhaseW-1:0] b,
                                                        logic [PedW-1:0]   ped,
                                                        logic [GainW-1:0]  gain);
    logic [PhaseW-1:0] d_lead;
    logic [PhaseW-1:0] d_pair;
    int                sum;
    int                prod;
    int                scaled;
    int                code;
    d_lead = a - prev;
    d_pair = b - a;
    sum    = int'($signed(d_lead)) + int'($signed(d_pair));
    prod   = sum * 8 * (int'(gain) + 1);
    // round half away from zero
    scaled = (prod < 0) ? -((2 - prod) / 4) : (prod + 2) / 4;
    code   = int'(ped) + scaled;
    if (code < 0) code = 0;
    if (code > 63) code = 63;
    return CodeW'(code);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pedestal_copy = PEDESTAL_RESET;
      gain_copy     = GAIN_RESET;
      prev_phase    = LAST_PHASE_RESET;
      errors        = 0;
      codes_owed_q.delete();
      mismatch_count_o <= 0;
      codes_owed_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IDX_PEDESTAL: pedestal_copy = cfg_data_i[PedW-1:0];
          CFG_IDX_GAIN:     gain_copy     = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      // retire before predicting: a code never leaves in the edge its request enters
      if (out_valid_i && out_ready_i) begin
        if (codes_owed_q.size() == 0) begin
          $display("%0t ERROR unexpected freq_code: expected none, actual %0d",
                   $time, freq_code_i);
          errors++;
        end else begin
          owed_code = codes_owed_q.pop_front();
          if (owed_code !== freq_code_i) begin
            $display("%0t ERROR freq_code mismatch: expected %0d, actual %0d",
                     $time, owed_code, freq_code_i);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        phase_a = quantize_phase(sample_first_i);
        phase_b = quantize_phase(sample_second_i);
        codes_owed_q.push_back(freq_from_phases(prev_phase, phase_a, phase_b,
                                                pedestal_copy, gain_copy));
        prev_phase = phase_b;
      end
      codes_owed_o     <= codes_owed_q.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

@@ test/fm_phase_delta_discriminator_test.sv @@
// Top of the FM phase-delta discriminator testbench: clock, reset, sample and register stimulus,
// output back-pressure and the verdict. Depends on fmpd_pkg, the block and its checker.
module fm_phase_delta_discriminator_test import fmpd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 100000;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 140;
  localparam int SettleSlack = 4;   // extra edges to wait after the last owed code is taken

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_first_i;
  logic [SampleW-1:0] sample_second_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [CodeW-1:0]   freq_code_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;

  int                 mismatch_count;
  int                 codes_owed;
  int                 cycles;
  bit                 quiet_mode;     // set to suppress random idling on both sides
  logic [SampleW-1:0] drift_byte;

  fm_phase_delta_discriminator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .freq_code_o     (freq_code_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  fm_phase_delta_discriminator_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_first_i   (sample_first_i),
    .sample_second_i  (sample_second_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .freq_code_i      (freq_code_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .codes_owed_o     (codes_owed)
  );

  always #5ns clk_i = ~clk_i;

  // Guard against a hung handshake: end the run as a failure at the limit.
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("fm_phase_delta_discriminator_test: FAIL");
    $finish;
  end

  // Offer one sample-pair request; return at the edge that accepts it.
  // Idle only by lowering valid before the request is raised, never while it waits.
  task automatic push_pair(input logic [SampleW-1:0] first, input logic [SampleW-1:0] second);
    while (!quiet_mode && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_first_i  <= first;
    sample_second_i <= second;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Issue one register write request, then drop valid for a cycle so back-to-back
  // writes never lower and raise valid in the same step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop the sample request, wait for every owed code, then let the pipeline empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (codes_owed != 0) @(posedge clk_i);
    repeat (SettleSlack) @(posedge clk_i);
  endtask

  // Nudge one nibble by one bucket, or leave the byte as it is, so consecutive phases stay close, like a real tone.
  function automatic logic [SampleW-1:0] nudge(input logic [SampleW-1:0] b);
    logic [SampleW-1:0] r;
    r = b;
    case ($urandom_range(4))
      0: r[3:0] = r[3:0] + 4'd1;
      1: r[3:0] = r[3:0] - 4'd1;
      2: r[7:4] = r[7:4] + 4'd1;
      3: r[7:4] = r[7:4] - 4'd1;
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stalls, plus long hold-offs counted here while the sender keeps going.
  initial begin
    int taken;
    int hold_left;
    int next_hold;
    taken     = 0;
    hold_left = 0;
    next_hold = 300;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (taken >= next_hold) begin
        hold_left = 250;
        next_hold = next_hold + 400;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 15);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [15:0] directed[$];
    logic [7:0]  first;
    logic [7:0]  second;
    int          mode;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sample_first_i  = '0;
    sample_second_i = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    quiet_mode      = 1'b0;
    drift_byte      = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs at reset settings: zero bytes (reset phase), all ones, the corner
    // buckets, both sides of the seam near +-pi, and large swings that clamp high and low.
    directed = '{16'h0000, 16'hFFFF, 16'h8008, 16'h8877, 16'h7FF7, 16'h0FF0,
                 16'h808F, 16'h8F80, 16'h7887, 16'h0110, 16'h7070, 16'h0707};
    foreach (directed[k]) push_pair(directed[k][15:8], directed[k][7:0]);
    settle();

    // Highest pedestal and gain, written with the spare bits set so they must be dropped.
    write_reg(CFG_IDX_PEDESTAL, 8'hFF);
    write_reg(CFG_IDX_GAIN, 8'hFF);
    // Writes to unknown indexes must change nothing.
    write_reg(CfgIdxW'(2), 8'h00);
    write_reg(CfgIdxW'(255), 8'h00);
    push_pair(8'h00, 8'h00);
    push_pair(8'h88, 8'h80);
    push_pair(8'hF0, 8'h0F);
    push_pair(8'h77, 8'h00);
    settle();

    // Lowest settings, again with spare bits set.
    write_reg(CFG_IDX_PEDESTAL, 8'hC0);
    write_reg(CFG_IDX_GAIN, 8'hF8);
    push_pair(8'h00, 8'h01);
    push_pair(8'hFF, 8'h88);
    push_pair(8'h7F, 8'h80);
    push_pair(8'h12, 8'h34);
    settle();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      // Hold both sides busy for one whole phase.
      quiet_mode = (phase == 3);
      case (phase)
        0: begin
          write_reg(CFG_IDX_PEDESTAL, 8'd0);
          write_reg(CFG_IDX_GAIN, 8'd7);
        end
        1: begin
          write_reg(CFG_IDX_GAIN, 8'd0);
          write_reg(CFG_IDX_PEDESTAL, 8'd63);
        end
        default: begin
          if ($urandom_range(1)) write_reg(CfgIdxW'($urandom_range(255, 2)), CfgDatW'($urandom));
          write_reg(CFG_IDX_PEDESTAL, CfgDatW'($urandom));
          write_reg(CFG_IDX_GAIN, CfgDatW'($urandom));
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        mode = $urandom_range(99);
        if (mode < 30) begin
          // noise: any byte pattern
          first  = 8'($urandom);
          second = 8'($urandom);
        end else if (mode < 40) begin
          // broken tone: a smooth first sample followed by a jump
          first  = nudge(drift_byte);
          second = 8'($urandom);
        end else begin
          // slowly rotating tone with random steps
          first  = nudge(drift_byte);
          second = nudge(first);
        end
        drift_byte = second;
        push_pair(first, second);
      end
      settle();
    end
    quiet_mode = 1'b0;

    if (mismatch_count == 0) begin
      $display("fm_phase_delta_discriminator_test: PASS");
    end else begin
      $display("fm_phase_delta_discriminator_test: FAIL");
    end
    $finish;
  end

endmodule
